>>> hw/rtl/ptt_pkg.sv
// Shared constants, codes and interface types of the periodic task timer table.
// Used by the controller, the datapath and the top level; depends on nothing else.
package ptt_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int MODE_W = 3;
	localparam int TASK_W = 8;
	localparam int PERIOD_W = 16;
	localparam int RSLOT_W = 3;
	localparam int STATE_W = 2;

	localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TICK     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd4;

	localparam logic [STATE_W-1:0] TSTATE_STOPPED   = 2'd0;
	localparam logic [STATE_W-1:0] TSTATE_READY     = 2'd1;
	localparam logic [STATE_W-1:0] TSTATE_NOT_FOUND = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic due;
		logic pend_valid;
		logic out_free;
		logic idx_last;
	} stat_t;

	// Slot index as reported on the result port: its low bits, zero extended.
	function automatic logic [RSLOT_W-1:0] slot_code(input logic [IDX_W-1:0] idx);
		logic [IDX_W+RSLOT_W-1:0] wide;
		wide = {{RSLOT_W{1'b0}}, idx};
		return wide[RSLOT_W-1:0];
	endfunction

endpackage

>>> hw/rtl/periodic_task_timer_table.sv
// Periodic task timer table: top level joining the controller and the datapath.
// A single result, or the final result of a dispatch, is loaded into the output
// register in the finish state after the scan; earlier dispatch announcements come
// out during the scan, which holds while one waits in the output and another is due.
// Items are taken one at a time; the scan visits one slot a cycle unless held.
// Reset (arst_n low) stops every slot, clears every id to zero and empties the output.
module periodic_task_timer_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ptt_pkg::MODE_W-1:0]       mode,
	input  logic [ptt_pkg::TASK_W-1:0]       task_id,
	input  logic [ptt_pkg::PERIOD_W-1:0]     period,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ptt_pkg::TASK_W-1:0]       result_task,
	output logic [ptt_pkg::RSLOT_W-1:0]      result_slot,
	output logic [ptt_pkg::STATE_W-1:0]      task_state,
	output logic                             fired,
	output logic                             last
);

	ptt_pkg::cmd_t  cmd;
	ptt_pkg::stat_t stat;

	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.task_id     (task_id),
		.period      (period),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_task (result_task),
		.result_slot (result_slot),
		.task_state  (task_state),
		.fired       (fired),
		.last        (last)
	);

endmodule

>>> hw/rtl/ptt_ctrl.sv
// Sequencing controller of the periodic task timer table.
// Depends on ptt_pkg for the command and status types.
module ptt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ptt_pkg::stat_t stat,
	output ptt_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.load = in_ready && in_valid;
		// A due slot needs the output register when a fired result is already pending.
		cmd.step = (state_q == S_SCAN) &&
			!(stat.due && stat.pend_valid && !stat.out_free);
		cmd.finish = (state_q == S_FINISH) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (cmd.step && stat.idx_last) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (cmd.finish) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/ptt_dp.sv
// Datapath of the periodic task timer table: slot table, scan index, pending
// dispatch result and output register. Depends on ptt_pkg.
module ptt_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ptt_pkg::cmd_t                    cmd,
	output ptt_pkg::stat_t                   stat,
	input  logic [ptt_pkg::MODE_W-1:0]       mode,
	input  logic [ptt_pkg::TASK_W-1:0]       task_id,
	input  logic [ptt_pkg::PERIOD_W-1:0]     period,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ptt_pkg::TASK_W-1:0]       result_task,
	output logic [ptt_pkg::RSLOT_W-1:0]      result_slot,
	output logic [ptt_pkg::STATE_W-1:0]      task_state,
	output logic                             fired,
	output logic                             last
);

	logic [ptt_pkg::TASK_W-1:0]   ids_q    [ptt_pkg::SLOT_COUNT];
	logic [ptt_pkg::PERIOD_W-1:0] cd_q     [ptt_pkg::SLOT_COUNT];
	logic [ptt_pkg::PERIOD_W-1:0] reload_q [ptt_pkg::SLOT_COUNT];
	logic [ptt_pkg::SLOT_COUNT-1:0] ready_q;

	logic [ptt_pkg::MODE_W-1:0]   mode_q;
	logic [ptt_pkg::TASK_W-1:0]   id_q;
	logic [ptt_pkg::PERIOD_W-1:0] per_q;
	logic [ptt_pkg::STATE_W-1:0]  st_q;
	logic [ptt_pkg::IDX_W-1:0]    idx_q;
	logic                         found_q;

	logic                         pend_valid_q;
	logic [ptt_pkg::TASK_W-1:0]   pend_task_q;
	logic [ptt_pkg::IDX_W-1:0]    pend_slot_q;

	logic                         out_valid_q;
	logic [ptt_pkg::TASK_W-1:0]   out_task_q;
	logic [ptt_pkg::RSLOT_W-1:0]  out_slot_q;
	logic [ptt_pkg::STATE_W-1:0]  out_state_q;
	logic                         out_fired_q;
	logic                         out_last_q;

	logic                         rd_ready;
	logic [ptt_pkg::TASK_W-1:0]   rd_id;
	logic [ptt_pkg::PERIOD_W-1:0] rd_cd;
	logic                         match;
	logic                         due;
	logic                         add_hit;
	logic                         out_free;

	always_comb begin
		rd_ready = ready_q[idx_q];
		rd_id = ids_q[idx_q];
		rd_cd = cd_q[idx_q];
		match = (rd_id == id_q);
		due = (mode_q == ptt_pkg::MODE_DISPATCH) && rd_ready &&
			(rd_cd == '0);
		add_hit = (mode_q == ptt_pkg::MODE_ADD) && !found_q && !rd_ready;
		out_free = !out_valid_q || out_ready;
		stat.due = due;
		stat.pend_valid = pend_valid_q;
		stat.out_free = out_free;
		stat.idx_last = (idx_q == ptt_pkg::IDX_W'(ptt_pkg::SLOT_COUNT - 1));
	end

	// Control state and the slot fields whose reset value is visible.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
				ids_q[i] <= '0;
			end
			ready_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				found_q <= 1'b0;
				pend_valid_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
				case (mode_q)
					ptt_pkg::MODE_ADD: begin
						if (add_hit) begin
							ids_q[idx_q] <= id_q;
							ready_q[idx_q] <= 1'b1;
							found_q <= 1'b1;
						end
					end
					ptt_pkg::MODE_DELETE: begin
						if (!found_q && match) begin
							ready_q[idx_q] <= 1'b0;
							found_q <= 1'b1;
						end
					end
					ptt_pkg::MODE_QUERY: begin
						if (match) found_q <= 1'b1;
					end
					ptt_pkg::MODE_DISPATCH: begin
						if (due) pend_valid_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end

			if ((cmd.step && due && pend_valid_q) || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			id_q <= task_id;
			per_q <= period;
			st_q <= (mode == ptt_pkg::MODE_QUERY) ? ptt_pkg::TSTATE_NOT_FOUND
				: ptt_pkg::TSTATE_STOPPED;
		end else if (cmd.step) begin
			case (mode_q)
				ptt_pkg::MODE_ADD: begin
					if (add_hit) begin
						cd_q[idx_q] <= per_q;
						reload_q[idx_q] <= per_q;
					end
				end
				ptt_pkg::MODE_QUERY: begin
					if (!found_q && match) begin
						st_q <= rd_ready ? ptt_pkg::TSTATE_READY
							: ptt_pkg::TSTATE_STOPPED;
					end
				end
				ptt_pkg::MODE_TICK: begin
					if (rd_ready) cd_q[idx_q] <= rd_cd - 1'b1;
				end
				ptt_pkg::MODE_DISPATCH: begin
					if (due) begin
						cd_q[idx_q] <= reload_q[idx_q];
						pend_task_q <= rd_id;
						pend_slot_q <= idx_q;
						// The earlier fired slot is now known not to be the final one.
						if (pend_valid_q) begin
							out_task_q <= pend_task_q;
							out_slot_q <= ptt_pkg::slot_code(pend_slot_q);
							out_state_q <= ptt_pkg::TSTATE_STOPPED;
							out_fired_q <= 1'b1;
							out_last_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.finish) begin
			out_last_q <= 1'b1;
			if (pend_valid_q) begin
				out_task_q <= pend_task_q;
				out_slot_q <= ptt_pkg::slot_code(pend_slot_q);
				out_state_q <= ptt_pkg::TSTATE_STOPPED;
				out_fired_q <= 1'b1;
			end else begin
				out_task_q <= id_q;
				out_slot_q <= '0;
				out_state_q <= st_q;
				out_fired_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result_task = out_task_q;
	assign result_slot = out_slot_q;
	assign task_state = out_state_q;
	assign fired = out_fired_q;
	assign last = out_last_q;

endmodule

>>> hw/rtl/ptt_checker.sv
// Port-level checks of the periodic task timer table, bound to the top level.
// Depends on ptt_pkg and periodic_task_timer_table.
module ptt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [ptt_pkg::TASK_W-1:0]       result_task,
	input logic [ptt_pkg::RSLOT_W-1:0]      result_slot,
	input logic [ptt_pkg::STATE_W-1:0]      task_state,
	input logic                             fired,
	input logic                             last
);

	// A result that is not taken stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_task) &&
		$stable(result_slot) && $stable(task_state) && $stable(fired) && $stable(last))
		else $error("output result changed before its transfer");

	// Only dispatch announcements can be followed by more results of the same item.
	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fired |-> last)
		else $error("result without fired is not marked last");

	a_plain_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fired |-> result_slot == '0)
		else $error("slot index reported on a result without fired");

	a_fired_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> task_state == ptt_pkg::TSTATE_STOPPED)
		else $error("query answer reported on a dispatch announcement");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_task (result_task),
	.result_slot (result_slot),
	.task_state  (task_state),
	.fired       (fired),
	.last        (last)
);

>>> dv/periodic_task_timer_table_tb.sv
// Self-checking testbench for the periodic task timer table.
// Holds its own slot table model, sends directed and random operations, checks every result.
// Depends on ptt_pkg and periodic_task_timer_table.
`timescale 1ns / 100ps

module periodic_task_timer_table_tb;

	localparam logic [ptt_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [ptt_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [ptt_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 160;

	typedef struct packed {
		logic [ptt_pkg::TASK_W-1:0]  id;
		logic [ptt_pkg::RSLOT_W-1:0] slot;
		logic [ptt_pkg::STATE_W-1:0] state;
		logic                        fired;
		logic                        last;
	} sched_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [ptt_pkg::MODE_W-1:0]   mode = '0;
	logic [ptt_pkg::TASK_W-1:0]   task_id = '0;
	logic [ptt_pkg::PERIOD_W-1:0] period = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [ptt_pkg::TASK_W-1:0]   result_task;
	logic [ptt_pkg::RSLOT_W-1:0]  result_slot;
	logic [ptt_pkg::STATE_W-1:0]  task_state;
	logic                         fired;
	logic                         last;

	// Model of the slot table.
	logic [ptt_pkg::TASK_W-1:0]   model_ids[ptt_pkg::SLOT_COUNT];
	logic [ptt_pkg::PERIOD_W-1:0] model_count[ptt_pkg::SLOT_COUNT];
	logic [ptt_pkg::PERIOD_W-1:0] model_reload[ptt_pkg::SLOT_COUNT];
	logic                         model_ready[ptt_pkg::SLOT_COUNT];

	sched_result_t sched_results_q[$];
	int fail_count = 0;
	int idle_enable = 1;
	int output_hold = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	periodic_task_timer_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.task_id    (task_id),
		.period     (period),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_task(result_task),
		.result_slot(result_slot),
		.task_state (task_state),
		.fired      (fired),
		.last       (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies one operation to the table model and queues the results it announces.
	function automatic void apply_table_op(input logic [ptt_pkg::MODE_W-1:0] op,
			input logic [ptt_pkg::TASK_W-1:0] id, input logic [ptt_pkg::PERIOD_W-1:0] per);
		sched_result_t r;
		bit done;
		int last_due;
		r = '{id: id, slot: '0, state: ptt_pkg::TSTATE_STOPPED, fired: 1'b0, last: 1'b1};
		done = 1'b0;
		last_due = -1;
		case (op)
			ptt_pkg::MODE_ADD: begin
				for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
					if (!done && !model_ready[i]) begin
						model_ids[i] = id;
						model_count[i] = per;
						model_reload[i] = per;
						model_ready[i] = 1'b1;
						done = 1'b1;
					end
				end
			end
			ptt_pkg::MODE_DELETE: begin
				for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
					if (!done && model_ids[i] == id) begin
						model_ready[i] = 1'b0;
						done = 1'b1;
					end
				end
			end
			ptt_pkg::MODE_QUERY: begin
				r.state = ptt_pkg::TSTATE_NOT_FOUND;
				for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
					if (!done && model_ids[i] == id) begin
						r.state = model_ready[i] ? ptt_pkg::TSTATE_READY
							: ptt_pkg::TSTATE_STOPPED;
						done = 1'b1;
					end
				end
			end
			ptt_pkg::MODE_TICK: begin
				for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++)
					if (model_ready[i])
						model_count[i] = model_count[i] - 1'b1;
			end
			ptt_pkg::MODE_DISPATCH: begin
				for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++)
					if (model_ready[i] && model_count[i] == '0)
						last_due = i;
				for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
					if (model_ready[i] && model_count[i] == '0) begin
						sched_results_q.push_back('{id: model_ids[i],
							slot: ptt_pkg::RSLOT_W'(i), state: ptt_pkg::TSTATE_STOPPED,
							fired: 1'b1, last: (i == last_due)});
						model_count[i] = model_reload[i];
					end
				end
			end
			default: ;
		endcase
		if (last_due < 0)
			sched_results_q.push_back(r);
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		sched_result_t want;
		if (out_valid && out_ready) begin
			if (sched_results_q.size() == 0) begin
				$error("result with none expected: result_task %0d, fired %0d",
					result_task, fired);
				fail_count++;
			end else begin
				want = sched_results_q.pop_front();
				check_field("result_task", want.id, result_task);
				check_field("result_slot", want.slot, result_slot);
				check_field("task_state", want.state, task_state);
				check_field("fired", want.fired, fired);
				check_field("last", want.last, last);
			end
		end
	end

	// Output side pacing: a long hold-off when asked, otherwise short random stalls while idling is enabled.
	always @(posedge clk) begin
		if (output_hold > 0) begin
			out_ready <= 1'b0;
			output_hold--;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (idle_enable != 0 && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(1, 4) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offers one operation and returns in the cycle of its transfer, valid left high.
	task automatic send_item(input logic [ptt_pkg::MODE_W-1:0] op,
			input logic [ptt_pkg::TASK_W-1:0] id, input logic [ptt_pkg::PERIOD_W-1:0] per);
		int bursts;
		bursts = 0;
		while (idle_enable != 0 && bursts < 3 && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			bursts++;
		end
		in_valid <= 1'b1;
		mode <= op;
		task_id <= id;
		period <= per;
		do @(posedge clk); while (!in_ready);
		apply_table_op(op, id, per);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sched_results_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ptt_pkg::TASK_W-1:0] pick_id();
		if ($urandom_range(0, 3) != 0)
			return ptt_pkg::TASK_W'($urandom_range(0, 15));
		return ptt_pkg::TASK_W'($urandom());
	endfunction

	function automatic logic [ptt_pkg::PERIOD_W-1:0] pick_period();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return ptt_pkg::PERIOD_W'($urandom_range(0, 4));
		if (roll < 9)
			return ptt_pkg::PERIOD_W'($urandom_range(0, 255));
		return ptt_pkg::PERIOD_W'($urandom());
	endfunction

	// Right after reset every id is zero, so id zero is found stopped in slot 0.
	task automatic test_reset_state();
		send_item(ptt_pkg::MODE_QUERY, 8'h00, 16'h0000);
		send_item(ptt_pkg::MODE_QUERY, 8'hFF, 16'hFFFF);
		send_item(ptt_pkg::MODE_DISPATCH, 8'hA5, 16'h5A5A);
	endtask

	task automatic test_unused_modes();
		send_item(MODE_SPARE_5, 8'h00, 16'hFFFF);
		send_item(MODE_SPARE_6, 8'h3C, 16'h1234);
		send_item(MODE_SPARE_7, 8'hFF, 16'h0000);
	endtask

	// Eight adds fill the table; the ninth must leave it unchanged.
	task automatic test_full_table();
		logic [ptt_pkg::TASK_W-1:0] ids[9] = '{8'h11, 8'h22, 8'h33, 8'hFF, 8'h00,
			8'h55, 8'h66, 8'h77, 8'h99};
		logic [ptt_pkg::PERIOD_W-1:0] pers[9] = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd3,
			16'd0, 16'd1, 16'h8000, 16'd5};
		for (int i = 0; i < 9; i++)
			send_item(ptt_pkg::MODE_ADD, ids[i], pers[i]);
		send_item(ptt_pkg::MODE_QUERY, 8'h99, 16'h0000);
	endtask

	// Zero periods fire at once, short periods fire after ticks, and ticks wrap at zero.
	task automatic test_due_dispatch();
		send_item(ptt_pkg::MODE_DISPATCH, 8'h01, 16'h0000);
		send_item(ptt_pkg::MODE_TICK, 8'h02, 16'h0000);
		send_item(ptt_pkg::MODE_DISPATCH, 8'h03, 16'h0000);
		send_item(ptt_pkg::MODE_TICK, 8'h04, 16'h0000);
		send_item(ptt_pkg::MODE_DISPATCH, 8'h05, 16'h0000);
	endtask

	// Deleting an id whose slot is already stopped still takes that slot.
	task automatic test_delete_stopped();
		send_item(ptt_pkg::MODE_DELETE, 8'h33, 16'h0000);
		send_item(ptt_pkg::MODE_DELETE, 8'h33, 16'h0000);
		send_item(ptt_pkg::MODE_QUERY, 8'h33, 16'h0000);
		send_item(ptt_pkg::MODE_ADD, 8'h80, 16'd4);
	endtask

	// Fill the table with zero-period tasks so every dispatch fires many times, then
	// block the output while dispatches keep coming.
	task automatic test_backpressure();
		for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++)
			if (model_ready[i])
				send_item(ptt_pkg::MODE_DELETE, model_ids[i], '0);
		for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++)
			send_item(ptt_pkg::MODE_ADD, ptt_pkg::TASK_W'(8'hC0 + i), '0);
		drain_results();
		output_hold = HOLD_CYCLES;
		repeat (6)
			send_item(ptt_pkg::MODE_DISPATCH, ptt_pkg::TASK_W'($urandom()),
				ptt_pkg::PERIOD_W'($urandom()));
		drain_results();
	endtask

	// Mostly tick then dispatch pairs, so tasks come due, mixed with table churn.
	task automatic test_random_mix(input int count);
		int sent;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_item(ptt_pkg::MODE_TICK, ptt_pkg::TASK_W'($urandom()),
					ptt_pkg::PERIOD_W'($urandom()));
				send_item(ptt_pkg::MODE_DISPATCH, ptt_pkg::TASK_W'($urandom()),
					ptt_pkg::PERIOD_W'($urandom()));
				sent += 2;
			end else begin
				if (pick < 55)
					send_item(ptt_pkg::MODE_ADD, pick_id(), pick_period());
				else if (pick < 67)
					send_item(ptt_pkg::MODE_DELETE, pick_id(),
						ptt_pkg::PERIOD_W'($urandom()));
				else if (pick < 82)
					send_item(ptt_pkg::MODE_QUERY, pick_id(),
						ptt_pkg::PERIOD_W'($urandom()));
				else if (pick < 91)
					send_item(ptt_pkg::MODE_DISPATCH, ptt_pkg::TASK_W'($urandom()),
						ptt_pkg::PERIOD_W'($urandom()));
				else if (pick < 96)
					send_item(ptt_pkg::MODE_TICK, ptt_pkg::TASK_W'($urandom()),
						ptt_pkg::PERIOD_W'($urandom()));
				else
					send_item(ptt_pkg::MODE_W'($urandom_range(int'(MODE_SPARE_5),
						int'(MODE_SPARE_7))), ptt_pkg::TASK_W'($urandom()),
						ptt_pkg::PERIOD_W'($urandom()));
				sent++;
			end
		end
	endtask

	// Back-to-back traffic with neither side idling.
	task automatic test_steady_stream();
		idle_enable = 0;
		test_random_mix(60);
	endtask

	initial begin
		for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
			model_ids[i] = '0;
			model_count[i] = '0;
			model_reload[i] = '0;
			model_ready[i] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_unused_modes();
		test_full_table();
		test_due_dispatch();
		test_delete_stopped();
		test_backpressure();
		test_random_mix(330);
		test_steady_stream();
		drain_results();
		repeat (ptt_pkg::SLOT_COUNT + 4) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
